/* sv/atc_pkg.sv */
package atc_pkg;

  // Stream payload widths
  localparam int OP_W       = 3;
  localparam int IN_DATA_W  = 224;  // seven 32-bit fields
  localparam int OUT_DATA_W = 384;  // twelve 32-bit matrix words

  // Edit codes
  localparam logic [OP_W-1:0] OP_TRANSLATE = 3'd0;
  localparam logic [OP_W-1:0] OP_ROTATE    = 3'd1;
  localparam logic [OP_W-1:0] OP_SCALE     = 3'd2;
  localparam logic [OP_W-1:0] OP_MIRROR    = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET     = 3'd4;

  // CORDIC datapath, Q30
  localparam int CW            = 36;
  localparam int CORDIC_STEPS  = 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [29:0] CORDIC_K   = 30'd652032874;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      default: v = 30'd1 << (5'd30 - i);  // atan(2^-i) == 2^-i in Q30 from here on
    endcase
    return v;
  endfunction

endpackage

/* sv/atc_mul.sv */
module atc_mul #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic                busy,
  output logic                done,
  output logic signed [W-1:0] q,
  output logic [63:0]         lo
);

  logic [63:0]  ua, ub;
  logic         neg;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         run, fin;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pps, rsum, qq, lim, qs;

  function automatic logic [63:0] mag(input logic signed [W-1:0] x);
    logic signed [63:0] v;
    v = 64'(x);
    return x < 0 ? 64'(-v) : 64'(v);
  endfunction

  // 32x32 partial products, one per cycle
  always_comb begin
    ah = cnt[0] ? ua[63:32] : ua[31:0];
    bh = cnt[1] ? ub[63:32] : ub[31:0];
    pp = ah * bh;
    case (cnt)
      2'd0:    pps = {64'd0, pp};
      2'd3:    pps = {pp, 64'd0};
      default: pps = {32'd0, pp, 32'd0};
    endcase
  end

  // round half away from zero on magnitude, then clamp
  always_comb begin
    rsum = acc + (128'd1 << (F - 1));
    qq   = rsum >> F;
    lim  = (128'd1 << (W - 1)) - 128'd1 + {127'd0, neg};
    qs   = (qq > lim) ? lim : qq;
  end

  assign busy = run | fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      if (start) begin
        ua  <= mag(a);
        ub  <= mag(b);
        neg <= (a < 0) != (b < 0);
        acc <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        acc <= acc + pps;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        fin <= 1'b0;
        q   <= neg ? -qs[W-1:0] : qs[W-1:0];
        lo  <= acc[63:0];
      end
    end
  end

endmodule

/* sv/atc_sqrt.sv */
module atc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n, res, bt, tr;
  logic [4:0]  cnt;
  logic        run;

  assign tr   = res + bt;
  assign root = res[31:0];

  // one result bit per cycle, from two bits of radicand
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == 5'd31);
      if (start) begin
        n   <= radicand;
        res <= '0;
        bt  <= 64'd1 << 62;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (n >= tr) begin
          n   <= n - tr;
          res <= (res >> 1) + bt;
        end else begin
          res <= res >> 1;
        end
        bt  <= bt >> 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) run <= 1'b0;
      end
    end
  end

endmodule

/* sv/atc_div.sv */
module atc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quo,
  output logic [63:0] rem
);

  logic [63:0] dv;
  logic [64:0] tmp;
  logic        ge;
  logic [5:0]  cnt;
  logic        run;

  assign tmp = {rem, quo[63]};
  assign ge  = tmp >= {1'b0, dv};

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == 6'd63);
      if (start) begin
        rem <= '0;
        quo <= dividend;
        dv  <= divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? 64'(tmp - {1'b0, dv}) : tmp[63:0];
        quo <= {quo[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) run <= 1'b0;
      end
    end
  end

endmodule

/* sv/atc_cordic.sv */
module atc_cordic #(
  parameter int F = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [atc_pkg::CW-1:0] z_in,
  output logic                 done,
  output logic signed [atc_pkg::CW-1:0] cos_q,
  output logic signed [atc_pkg::CW-1:0] sin_q
);
  import atc_pkg::*;

  localparam int SH = 30 - F;
  localparam logic signed [CW-1:0] HALF = (CW'(1) <<< SH) >>> 1;

  logic signed [CW-1:0] x, y, z, xs, ys, at;
  logic [4:0] cnt;
  logic       run;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = signed'({{(CW-30){1'b0}}, atan_q30(cnt)});

  // Q30 back to the working fraction, round half up
  assign cos_q = (x + HALF) >>> SH;
  assign sin_q = (y + HALF) >>> SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == 5'(CORDIC_STEPS - 1));
      if (start) begin
        x   <= signed'({{(CW-30){1'b0}}, CORDIC_K});
        y   <= '0;
        z   <= z_in;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (!z[CW-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) run <= 1'b0;
      end
    end
  end

endmodule

/* sv/affine_transform_accumulator.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = op, s_tdata = point xyz, dir xyz, amount
// m_*       out  m_tvalid/m_tready  m_tdata = m00..m23, row-major
//
// One edit transaction takes longest for rotate, less for scale and mirror, less
// again for translate and least for reset. The time is set by the single shared
// multiplier (up to 36 products for the compose), the iterative divider and square
// root and the 30-step CORDIC.
// Synchronous active-high reset loads the identity matrix. s_tready is high only
// while the sequencer is idle; a result waiting on m_tready stalls the next edit
// only when it is finished and needs the output register.
module affine_transform_accumulator #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // point_x, point_y, point_z, dir_x, dir_y, dir_z, amount (32 bits each, low first)
  input  logic [atc_pkg::IN_DATA_W-1:0]   s_tdata,
  // op
  input  logic [atc_pkg::OP_W-1:0]        s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23 (32 bits each, low first)
  output logic [atc_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import atc_pkg::*;

  localparam int W = WORD_WIDTH;
  localparam int F = FRAC_BITS;

  typedef logic signed [W-1:0] word_t;

  localparam word_t VMAX = word_t'({1'b0, {(W-1){1'b1}}});
  localparam word_t VMIN = word_t'({1'b1, {(W-1){1'b0}}});
  localparam logic signed [63:0] VMAX64 = 64'(VMAX);
  localparam logic signed [63:0] VMIN64 = 64'(VMIN);
  localparam word_t ONE  = (F <= W - 2) ? word_t'(64'sd1 <<< F) : VMAX;
  localparam word_t NEG2 = (F + 1 <= W - 1) ? word_t'(-(64'sd2 <<< F)) : VMIN;

  // 2*pi in the working fraction, round half up
  localparam logic [63:0] TP = ((TWO_PI_Q30 << 1) + (64'd1 << (30 - F))) >> (31 - F);
  localparam logic signed [CW-1:0] TP_C = signed'(CW'(TP));
  localparam logic signed [CW-1:0] PI_C = signed'(CW'(TP >> 1));
  localparam logic signed [CW-1:0] HP_C = signed'(CW'(TP >> 2));

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;   // sum of squared axis terms
  localparam logic [3:0] S_SQRT  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;   // axis normalize
  localparam logic [3:0] S_DISP  = 4'd4;
  localparam logic [3:0] S_ANG   = 4'd5;   // angle mod 2*pi
  localparam logic [3:0] S_CORD  = 4'd6;
  localparam logic [3:0] S_BUILD = 4'd7;   // d*I + k*n*n^T
  localparam logic [3:0] S_CROSS = 4'd8;   // rotate skew terms
  localparam logic [3:0] S_CTR   = 4'd9;   // t = c - L*c
  localparam logic [3:0] S_COMP  = 4'd10;  // T * M
  localparam logic [3:0] S_COPY  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  function automatic word_t sat64(input logic signed [63:0] v);
    if (v > VMAX64) return VMAX;
    if (v < VMIN64) return VMIN;
    return word_t'(v);
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic word_t sneg(input word_t a);
    return (a == VMIN) ? VMAX : -a;
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    return sadd(a, sneg(b));
  endfunction

  function automatic logic [63:0] mag64(input word_t a);
    logic signed [63:0] v;
    v = 64'(a);
    return a < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic word_t in_word(input logic [31:0] f);
    return sat64(64'(signed'(f)));
  endfunction

  logic [3:0]  state;
  logic [1:0]  ph, rr, jj, ii;
  logic [2:0]  ee;
  logic [OP_W-1:0] op;
  word_t       pv [3];
  word_t       dv [3];
  word_t       nv [3];
  word_t       amt, dd, kk, sv, tmp, acc;
  word_t       tm [12];
  word_t       mm [12];
  word_t       nm [12];
  logic        has_axis, flip;
  logic [63:0] ssum;
  logic [31:0] rval;

  // shared unit hookups
  logic        mul_start, mul_busy, mul_done;
  word_t       mul_a, mul_b, mul_q;
  logic [63:0] mul_lo;
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [63:0] div_num, div_den, div_quo, div_rem;
  logic        cor_start, cor_done;
  logic signed [CW-1:0] cor_z, cor_cos, cor_sin;

  atc_mul #(.W(W), .F(F)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .q(mul_q), .lo(mul_lo)
  );

  atc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(ssum + mul_lo),
    .done(sqrt_done), .root(sqrt_root)
  );

  atc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num), .divisor(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  atc_cordic #(.F(F)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .z_in(cor_z),
    .done(cor_done), .cos_q(cor_cos), .sin_q(cor_sin)
  );

  assign s_tready = (state == S_IDLE);

  // skew-term table: target element, axis component, add or subtract
  logic [3:0] cr_t;
  logic [1:0] cr_n;
  logic       cr_add;
  always_comb begin
    case (ee)
      3'd0:    begin cr_t = 4'd1; cr_n = 2'd2; cr_add = 1'b0; end
      3'd1:    begin cr_t = 4'd2; cr_n = 2'd1; cr_add = 1'b1; end
      3'd2:    begin cr_t = 4'd4; cr_n = 2'd2; cr_add = 1'b1; end
      3'd3:    begin cr_t = 4'd6; cr_n = 2'd0; cr_add = 1'b0; end
      3'd4:    begin cr_t = 4'd8; cr_n = 2'd1; cr_add = 1'b0; end
      default: begin cr_t = 4'd9; cr_n = 2'd0; cr_add = 1'b1; end
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = dv[ii];
        mul_b = dv[ii];
      end
      S_BUILD: begin
        mul_a = ph[1] ? tmp : kk;
        mul_b = ph[1] ? nv[jj] : nv[rr];
      end
      S_CROSS: begin
        mul_a = sv;
        mul_b = nv[cr_n];
      end
      S_CTR: begin
        mul_a = tm[{rr, jj}];
        mul_b = pv[jj];
      end
      S_COMP: begin
        mul_a = tm[{rr, ii}];
        mul_b = mm[{ii, jj}];
      end
      default: ;
    endcase
  end

  assign mul_start = ((state inside {S_SQ, S_CROSS, S_CTR, S_COMP}) && ph == 2'd0) ||
                     (state == S_BUILD && (ph == 2'd0 || ph == 2'd2));
  assign sqrt_start = (state == S_SQ) && ph[0] && mul_done && (ii == 2'd2);
  assign div_start  = (state == S_DIV || state == S_ANG) && ph == 2'd0;

  always_comb begin
    if (state == S_ANG) begin
      div_num = mag64(amt);
      div_den = TP;
    end else begin
      div_num = (mag64(dv[ii]) << F) + 64'(rval >> 1);
      div_den = 64'(rval);
    end
  end

  // angle reduction into [-pi/2, pi/2] with a half-turn flag
  logic signed [CW-1:0] r0, r1, r2;
  logic                 fold;
  always_comb begin
    r0 = signed'(CW'(div_rem));
    if (amt < 0 && div_rem != 64'd0) r0 = TP_C - r0;
    r1 = (r0 > PI_C) ? r0 - TP_C : r0;
    fold = 1'b0;
    r2 = r1;
    if (r1 > HP_C) begin
      r2 = r1 - PI_C;
      fold = 1'b1;
    end else if (r1 < -HP_C) begin
      r2 = r1 + PI_C;
      fold = 1'b1;
    end
    cor_z = r2 <<< (30 - F);
  end
  assign cor_start = (state == S_ANG) && ph[0] && div_done;

  // CORDIC results with the half-turn applied
  word_t c_w, s_w;
  always_comb begin
    c_w = sat64(64'(flip ? -cor_cos : cor_cos));
    s_w = sat64(64'(flip ? -cor_sin : cor_sin));
  end

  // accumulator for dot products
  word_t acc_new, comp_val, n_q;
  logic  first;
  always_comb begin
    first    = (state == S_CTR) ? (jj == 2'd0) : (ii == 2'd0);
    acc_new  = sadd(first ? word_t'(0) : acc, mul_q);
    comp_val = (jj == 2'd3) ? sadd(acc_new, tm[{rr, 2'd3}]) : acc_new;
    n_q      = sat64(dv[ii] < 0 ? -signed'(div_quo) : signed'(div_quo));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      ph       <= '0;
      rr       <= '0;
      jj       <= '0;
      ii       <= '0;
      ee       <= '0;
      for (int k = 0; k < 12; k++) mm[k] <= (k % 5 == 0) ? ONE : word_t'(0);
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op   <= s_tuser;
            for (int k = 0; k < 3; k++) begin
              pv[k] <= in_word(s_tdata[32*k +: 32]);
              dv[k] <= in_word(s_tdata[32*(k+3) +: 32]);
            end
            amt  <= in_word(s_tdata[192 +: 32]);
            for (int k = 0; k < 12; k++) tm[k] <= (k % 5 == 0) ? ONE : word_t'(0);
            ssum <= '0;
            ph   <= '0;
            ii   <= '0;
            has_axis <= 1'b0;
            state <= (s_tuser == OP_ROTATE || s_tuser == OP_SCALE || s_tuser == OP_MIRROR)
                     ? S_SQ : S_DISP;
          end
        end
        S_SQ: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (mul_done) begin
            ssum <= ssum + mul_lo;
            ph   <= 2'd0;
            if (ii == 2'd2) state <= S_SQRT;
            else ii <= ii + 2'd1;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            rval <= sqrt_root;
            ii   <= '0;
            ph   <= '0;
            if (sqrt_root == 32'd0) begin
              for (int k = 0; k < 3; k++) nv[k] <= '0;
              state <= S_DISP;
            end else begin
              has_axis <= 1'b1;
              state    <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (div_done) begin
            nv[ii] <= n_q;
            ph     <= 2'd0;
            if (ii == 2'd2) state <= S_DISP;
            else ii <= ii + 2'd1;
          end
        end
        S_DISP: begin
          ph  <= '0;
          rr  <= '0;
          jj  <= '0;
          ii  <= '0;
          ee  <= '0;
          case (op)
            OP_TRANSLATE: begin
              tm[3]  <= pv[0];
              tm[7]  <= pv[1];
              tm[11] <= pv[2];
              state  <= S_COMP;
            end
            OP_ROTATE: state <= (has_axis && amt != word_t'(0)) ? S_ANG : S_COMP;
            OP_SCALE: begin
              dd    <= has_axis ? ONE : amt;
              kk    <= has_axis ? ssub(amt, ONE) : word_t'(0);
              state <= S_BUILD;
            end
            OP_MIRROR: begin
              dd    <= ONE;
              kk    <= NEG2;
              state <= has_axis ? S_BUILD : S_COMP;
            end
            OP_RESET: begin
              for (int k = 0; k < 12; k++) mm[k] <= (k % 5 == 0) ? ONE : word_t'(0);
              state <= S_DONE;
            end
            default: state <= S_DONE;  // unused codes leave the matrix as is
          endcase
        end
        S_ANG: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (div_done) begin
            flip  <= fold;
            ph    <= 2'd0;
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (cor_done) begin
            dd    <= c_w;
            kk    <= ssub(ONE, c_w);
            sv    <= s_w;
            state <= S_BUILD;
          end
        end
        S_BUILD: begin
          case (ph)
            2'd1: if (mul_done) begin
              tmp <= mul_q;
              ph  <= 2'd2;
            end
            2'd3: if (mul_done) begin
              tm[{rr, jj}] <= sadd((rr == jj) ? dd : word_t'(0), mul_q);
              ph <= 2'd0;
              if (jj == 2'd2) begin
                jj <= '0;
                if (rr == 2'd2) begin
                  rr    <= '0;
                  state <= (op == OP_ROTATE) ? S_CROSS : S_CTR;
                end else rr <= rr + 2'd1;
              end else jj <= jj + 2'd1;
            end
            default: ph <= ph + 2'd1;
          endcase
        end
        S_CROSS: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (mul_done) begin
            tm[cr_t] <= cr_add ? sadd(tm[cr_t], mul_q) : ssub(tm[cr_t], mul_q);
            ph <= 2'd0;
            if (ee == 3'd5) state <= S_CTR;
            else ee <= ee + 3'd1;
          end
        end
        S_CTR: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (mul_done) begin
            acc <= acc_new;
            ph  <= 2'd0;
            if (jj == 2'd2) begin
              tm[{rr, 2'd3}] <= ssub(pv[rr], acc_new);
              jj <= '0;
              if (rr == 2'd2) begin
                rr    <= '0;
                state <= S_COMP;
              end else rr <= rr + 2'd1;
            end else jj <= jj + 2'd1;
          end
        end
        S_COMP: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (mul_done) begin
            acc <= acc_new;
            ph  <= 2'd0;
            if (ii == 2'd2) begin
              nm[{rr, jj}] <= comp_val;
              ii <= '0;
              if (jj == 2'd3) begin
                jj <= '0;
                if (rr == 2'd2) state <= S_COPY;
                else rr <= rr + 2'd1;
              end else jj <= jj + 2'd1;
            end else ii <= ii + 2'd1;
          end
        end
        S_COPY: begin
          for (int k = 0; k < 12; k++) mm[k] <= nm[k];
          state <= S_DONE;
        end
        S_DONE: begin
          // hold here while an older result still sits in the output register
          if (!m_tvalid || m_tready) begin
            for (int k = 0; k < 12; k++) m_tdata[32*k +: 32] <= 32'(mm[k]);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // shared multiplier is never restarted mid-product
  a_mul_free: assert property (@(posedge clk) disable iff (rst) mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  // one iterative unit launched at a time
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_start, sqrt_start, div_start, cor_start}))
    else $error("two shared units started together");

  // normalize and angle divides never see a zero divisor
  a_div_nz: assert property (@(posedge clk) disable iff (rst) div_start |-> div_den != 64'd0)
    else $error("divide by zero");

  // a new result appears only from the completion state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result issued outside completion");

endmodule
